/* hw/rtl/xprd_pkg.sv */
// ----------------------------------------------------------------------------
// xprd_pkg: shared types and constants for the pattern row decoder
// Beat op format between front and back, effect codes, note divider table.
// ----------------------------------------------------------------------------
`default_nettype none

package xprd_pkg;

  // fixed geometry
  localparam int CHANNEL_COUNT      = 4;
  localparam int CH_W               = 2;
  localparam int NOTE_TABLE_ENTRIES = 97;
  localparam int QUEUE_DEPTH_DEF    = 4;

  // widths of per-channel state
  localparam int DIV_W  = 16;
  localparam int FREQ_W = 17;
  localparam int DET_W  = 14;
  localparam int QUOT_W = 10;

  // divide by 100 as multiply by reciprocal: x / 100 == (x * 167773) >> 24
  localparam int              RECIP_W     = 18;
  localparam logic [17:0]     RECIP_100   = 18'd167773;
  localparam int              RECIP_SHIFT = 24;

  // entry decode
  localparam logic [4:0] FM_RAW_FIELDS = 5'h1E;
  localparam logic [4:0] FM_AFTER_NOTE = 5'h1E;
  localparam logic [4:0] FM_AFTER_INST = 5'h1C;
  localparam logic [4:0] FM_AFTER_VOL  = 5'h18;
  localparam logic [4:0] FM_AFTER_EFF  = 5'h10;
  localparam logic [CH_W-1:0] CH_LAST  = CH_W'(CHANNEL_COUNT - 1);

  // effect codes
  localparam logic [7:0] EFF_JUMP  = 8'h0B;
  localparam logic [7:0] EFF_SPEED = 8'h0F;
  localparam logic [7:0] EFF_EXT   = 8'h0E;
  localparam logic [3:0] EXT_FINETUNE = 4'h5;
  localparam logic [7:0] SPEED_LIMIT  = 8'h20;
  localparam logic [4:0] FINETUNE_BIAS = 5'd8;

  // row result
  localparam logic [7:0] MASK_FIRST_ROW = 8'hC5;
  localparam logic [7:0] CHAN_BIT [CHANNEL_COUNT] = '{8'h01, 8'h40, 8'h04, 8'h80};
  localparam logic [7:0] INIT_SPEED_RST = 8'd6;

  // what the front tells the back to do with one byte
  typedef enum logic [2:0] {
    OP_SKIP,
    OP_LEAD,
    OP_NOTE,
    OP_INSTR,
    OP_PARAM
  } op_kind_t;

  typedef struct packed {
    op_kind_t        kind;
    logic [CH_W-1:0] ch;
    logic [7:0]      data;
    logic [7:0]      eff;
    logic            pat_start;
    logic            row_end;
  } op_t;

  localparam logic [DIV_W-1:0] NOTE_DIV_ROM [NOTE_TABLE_ENTRIES] = '{
    16'h0000, 16'h0020, 16'h0022, 16'h0040, 16'h0041, 16'h0080, 16'h00FE, 16'h00FF,
    16'h0100, 16'h0196, 16'h01AF, 16'h01C8, 16'h01E3, 16'h0200, 16'h021E, 16'h023F,
    16'h0261, 16'h0285, 16'h02AB, 16'h02D4, 16'h02FF, 16'h032D, 16'h035D, 16'h0390,
    16'h03C7, 16'h0400, 16'h043D, 16'h047D, 16'h04C2, 16'h050A, 16'h0557, 16'h05A8,
    16'h05FE, 16'h065A, 16'h06BA, 16'h0721, 16'h078D, 16'h0800, 16'h087A, 16'h08FB,
    16'h0984, 16'h0A14, 16'h0AAE, 16'h0B50, 16'h0BFD, 16'h0CB3, 16'h0D74, 16'h0E41,
    16'h0F1A, 16'h1000, 16'h10F4, 16'h11F6, 16'h1307, 16'h1429, 16'h155C, 16'h16A1,
    16'h17F9, 16'h1966, 16'h1AE9, 16'h1C82, 16'h1E34, 16'h2000, 16'h21E7, 16'h23EB,
    16'h260E, 16'h2851, 16'h2AB7, 16'h2D41, 16'h2FF2, 16'h32CC, 16'h35D1, 16'h3905,
    16'h3C68, 16'h4000, 16'h43CE, 16'h47D6, 16'h4C1C, 16'h50A3, 16'h556E, 16'h5A83,
    16'h5FE4, 16'h6598, 16'h6BA3, 16'h7209, 16'h78D1, 16'h8000, 16'h879D, 16'h8FAD,
    16'h9838, 16'hA145, 16'hAADC, 16'hB505, 16'hBFC9, 16'hCB30, 16'hD745, 16'hE412,
    16'hF1A2
  };

  // note number to divider; silence and out-of-range notes give 0
  function automatic logic [DIV_W-1:0] note_divider(input logic [7:0] note);
    logic [DIV_W-1:0] res;
    res = '0;
    if (note < 8'(NOTE_TABLE_ENTRIES)) begin
      res = NOTE_DIV_ROM[note[6:0]];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/xm_pattern_row_decoder.sv */
// ----------------------------------------------------------------------------
// xm_pattern_row_decoder: packed XM pattern decoder, four channels
// Takes one pattern byte per beat; emits one row result per four entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one pattern byte per beat, with
//   in_pattern_start high on the first byte of a pattern.
//   Output channel (out_valid / out_stall): one beat per completed row,
//   carrying change mask, speed, four frequencies, four instruments and
//   the loop point.
//   Config: cfg_wr_en / cfg_wr_data write the initial speed (reset 6);
//   write only while no row is in flight.
//   Throughput: one byte per cycle while the queue is not full. The parser
//   classifies a byte in the cycle it is accepted; the row engine executes
//   one op per cycle unless a row-ending op waits on a stalled output.
//   The result of a row goes through a queue slot, then the output register.
//   Stall: out_stall holds the result register; the row engine waits on a
//   row-ending op while the queue keeps taking bytes until it is full,
//   then in_stall rises.
//   Reset (rst_n low, synchronous): queue empty, state cleared, first-row
//   flag set, speed 6.
// ----------------------------------------------------------------------------
`default_nettype none

module xm_pattern_row_decoder #(
  parameter int QUEUE_DEPTH = xprd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_pattern_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_change_mask,
  output logic [7:0]       out_row_speed,
  output logic [15:0]      out_freq_ch0,
  output logic [15:0]      out_freq_ch1,
  output logic [15:0]      out_freq_ch2,
  output logic [15:0]      out_freq_ch3,
  output logic [7:0]       out_instrument_ch0,
  output logic [7:0]       out_instrument_ch1,
  output logic [7:0]       out_instrument_ch2,
  output logic [7:0]       out_instrument_ch3,
  output logic [7:0]       out_loop_point
);
  import xprd_pkg::*;

  logic q_full;
  logic push_valid;
  op_t  push_op;
  logic pop_valid;
  logic pop_ready;
  op_t  pop_op;

  // byte parser
  xprd_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_pattern_start (in_pattern_start),
    .q_full           (q_full),
    .op_valid         (push_valid),
    .op               (push_op)
  );

  // op queue
  xprd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_op    (push_op),
    .full       (q_full),
    .pop_ready  (pop_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op)
  );

  // row engine
  xprd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .op_valid           (pop_valid),
    .op                 (pop_op),
    .op_ready           (pop_ready),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_change_mask    (out_change_mask),
    .out_row_speed      (out_row_speed),
    .out_freq_ch0       (out_freq_ch0),
    .out_freq_ch1       (out_freq_ch1),
    .out_freq_ch2       (out_freq_ch2),
    .out_freq_ch3       (out_freq_ch3),
    .out_instrument_ch0 (out_instrument_ch0),
    .out_instrument_ch1 (out_instrument_ch1),
    .out_instrument_ch2 (out_instrument_ch2),
    .out_instrument_ch3 (out_instrument_ch3),
    .out_loop_point     (out_loop_point)
  );

endmodule

`default_nettype wire

/* hw/rtl/xprd_front.sv */
// ----------------------------------------------------------------------------
// xprd_front: pattern byte parser
// Tracks entry phase, field mask, effect type and channel; turns each input
// beat into one op for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module xprd_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_pattern_start,
  input  wire logic         q_full,
  output logic              op_valid,
  output xprd_pkg::op_t     op
);
  import xprd_pkg::*;

  logic            in_entry_r, in_entry_nxt;
  logic [4:0]      fm_r, fm_nxt;
  logic [7:0]      eff_r, eff_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;

  logic            ph;
  logic [4:0]      fm;
  logic [7:0]      eff;
  logic [CH_W-1:0] ch;
  op_kind_t        kind;
  logic            done;

  assign in_stall = q_full;
  assign op_valid = in_valid && !q_full;

  // classify the byte; a pattern start restarts at channel 0's lead byte
  always_comb begin
    ph  = in_pattern_start ? 1'b0 : in_entry_r;
    fm  = in_pattern_start ? 5'd0 : fm_r;
    eff = in_pattern_start ? 8'd0 : eff_r;
    ch  = in_pattern_start ? '0   : ch_r;

    fm_nxt  = fm;
    eff_nxt = eff;
    kind    = OP_SKIP;
    if (!ph) begin
      eff_nxt = '0;
      if (in_data_byte[7]) begin
        fm_nxt = in_data_byte[4:0];
        kind   = OP_LEAD;
      end else begin
        fm_nxt = FM_RAW_FIELDS;
        kind   = OP_NOTE;
      end
    end else if (fm[0]) begin
      fm_nxt = fm & FM_AFTER_NOTE;
      kind   = OP_NOTE;
    end else if (fm[1]) begin
      fm_nxt = fm & FM_AFTER_INST;
      kind   = OP_INSTR;
    end else if (fm[2]) begin
      fm_nxt = fm & FM_AFTER_VOL;
    end else if (fm[3]) begin
      fm_nxt  = fm & FM_AFTER_EFF;
      eff_nxt = in_data_byte;
    end else begin
      fm_nxt = '0;
      kind   = OP_PARAM;
    end

    // entry ends when no fields remain
    done = (fm_nxt == 5'd0);
    if (done) begin
      in_entry_nxt = 1'b0;
      eff_nxt      = '0;
      ch_nxt       = ch + 1'b1;
    end else begin
      in_entry_nxt = 1'b1;
      ch_nxt       = ch;
    end

    op.kind      = kind;
    op.ch        = ch;
    op.data      = in_data_byte;
    op.eff       = eff;
    op.pat_start = in_pattern_start;
    op.row_end   = done && (ch == CH_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_entry_r <= 1'b0;
      fm_r       <= '0;
      eff_r      <= '0;
      ch_r       <= '0;
    end else if (op_valid) begin
      in_entry_r <= in_entry_nxt;
      fm_r       <= fm_nxt;
      eff_r      <= eff_nxt;
      ch_r       <= ch_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xprd_queue.sv */
// ----------------------------------------------------------------------------
// xprd_queue: small op queue between front and back
// Flip-flop FIFO; lets the parser and the row engine stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module xprd_queue #(
  parameter int DEPTH = xprd_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_valid,
  input  wire xprd_pkg::op_t push_op,
  output logic               full,
  input  wire logic          pop_ready,
  output logic               pop_valid,
  output xprd_pkg::op_t      pop_op
);
  import xprd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_op    = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/xprd_back.sv */
// ----------------------------------------------------------------------------
// xprd_back: channel state and row result engine
// Executes one op per cycle on the per-channel state and loads the output
// register at each row end; a row-ending op waits while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module xprd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  input  wire logic          op_valid,
  input  wire xprd_pkg::op_t op,
  output logic               op_ready,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [7:0]         out_change_mask,
  output logic [7:0]         out_row_speed,
  output logic [15:0]        out_freq_ch0,
  output logic [15:0]        out_freq_ch1,
  output logic [15:0]        out_freq_ch2,
  output logic [15:0]        out_freq_ch3,
  output logic [7:0]         out_instrument_ch0,
  output logic [7:0]         out_instrument_ch1,
  output logic [7:0]         out_instrument_ch2,
  output logic [7:0]         out_instrument_ch3,
  output logic [7:0]         out_loop_point
);
  import xprd_pkg::*;

  // config
  logic [7:0] init_speed_r;

  // channel state
  logic [DIV_W-1:0]  div_r       [CHANNEL_COUNT];
  logic [DIV_W-1:0]  div_nxt     [CHANNEL_COUNT];
  logic [QUOT_W-1:0] quot_r      [CHANNEL_COUNT];
  logic [QUOT_W-1:0] quot_nxt    [CHANNEL_COUNT];
  logic [7:0]        inst_r      [CHANNEL_COUNT];
  logic [7:0]        inst_nxt    [CHANNEL_COUNT];
  logic [7:0]        inst_prev_r [CHANNEL_COUNT];
  logic [7:0]        inst_prev_nxt [CHANNEL_COUNT];
  logic [FREQ_W-1:0] freq_prev_r [CHANNEL_COUNT];
  logic [FREQ_W-1:0] freq_prev_nxt [CHANNEL_COUNT];
  logic [DET_W-1:0]  det_r       [CHANNEL_COUNT];
  logic [DET_W-1:0]  det_nxt     [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] trig_r, trig_nxt;
  logic [7:0] speed_r, speed_nxt;
  logic [7:0] loop_r, loop_nxt;
  logic       first_r, first_nxt;

  // output register
  logic              out_valid_r;
  logic [7:0]        mask_r, mask_nxt;
  logic [7:0]        ospeed_r;
  logic [7:0]        oloop_r;
  logic [15:0]       ofreq_r  [CHANNEL_COUNT];
  logic [15:0]       ofreq_nxt [CHANNEL_COUNT];
  logic [7:0]        oinst_r  [CHANNEL_COUNT];
  logic [7:0]        oinst_nxt [CHANNEL_COUNT];

  logic                        out_free, pop, out_load;
  logic [DIV_W-1:0]            new_div;
  logic [DIV_W+RECIP_W-1:0]    quot_prod;
  logic [QUOT_W-1:0]           new_quot;
  logic signed [4:0]           ft_steps;
  logic signed [15:0]          det_prod;
  logic [FREQ_W-1:0]           f;

  assign out_free = !out_valid_r || !out_stall;
  assign op_ready = !op.row_end || out_free;
  assign pop      = op_valid && op_ready;
  assign out_load = pop && op.row_end;

  // note lookup and quotient for finetune
  assign new_div   = note_divider(op.data);
  assign quot_prod = new_div * RECIP_100;
  assign new_quot  = quot_prod[RECIP_SHIFT +: QUOT_W];

  // finetune: (divider / 100) * (x - 8)
  assign ft_steps = $signed({1'b0, op.data[3:0]}) - $signed(FINETUNE_BIAS);
  assign det_prod = $signed({1'b0, quot_r[op.ch]}) * ft_steps;

  always_comb begin
    div_nxt       = div_r;
    quot_nxt      = quot_r;
    inst_nxt      = inst_r;
    inst_prev_nxt = inst_prev_r;
    freq_prev_nxt = freq_prev_r;
    det_nxt       = det_r;
    trig_nxt      = trig_r;
    speed_nxt     = speed_r;
    loop_nxt      = loop_r;
    first_nxt     = first_r;
    mask_nxt      = '0;
    ofreq_nxt     = ofreq_r;
    oinst_nxt     = oinst_r;
    f             = '0;

    if (pop) begin
      // pattern start clears channel state first
      if (op.pat_start) begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          div_nxt[CH_W'(c)]       = '0;
          quot_nxt[CH_W'(c)]      = '0;
          inst_nxt[CH_W'(c)]      = '0;
          inst_prev_nxt[CH_W'(c)] = '0;
          freq_prev_nxt[CH_W'(c)] = '0;
          det_nxt[CH_W'(c)]       = '0;
        end
        trig_nxt  = '0;
        first_nxt = 1'b1;
        speed_nxt = init_speed_r;
      end

      case (op.kind)
        OP_LEAD: begin
          trig_nxt[op.ch] = 1'b0;
        end
        OP_NOTE: begin
          div_nxt[op.ch]  = new_div;
          quot_nxt[op.ch] = new_quot;
          trig_nxt[op.ch] = 1'b1;
        end
        OP_INSTR: begin
          inst_nxt[op.ch] = op.data;
        end
        OP_PARAM: begin
          case (op.eff)
            EFF_JUMP: begin
              loop_nxt = {op.data[6:0], 1'b0};
            end
            EFF_SPEED: begin
              if (op.data < SPEED_LIMIT) begin
                speed_nxt = op.data;
              end
            end
            EFF_EXT: begin
              if (op.data[7:4] == EXT_FINETUNE) begin
                det_nxt[op.ch] = det_prod[DET_W-1:0];
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase

      // row end: build result from the updated state
      if (op.row_end) begin
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
          if (div_nxt[CH_W'(c)] == '0) begin
            inst_nxt[CH_W'(c)] = '0;
          end
          f = {1'b0, div_nxt[CH_W'(c)]}
            + {{(FREQ_W-DET_W){det_nxt[CH_W'(c)][DET_W-1]}}, det_nxt[CH_W'(c)]};
          if (trig_nxt[CH_W'(c)] || (f != freq_prev_nxt[CH_W'(c)]) ||
              (inst_nxt[CH_W'(c)] != inst_prev_nxt[CH_W'(c)])) begin
            mask_nxt = mask_nxt | CHAN_BIT[CH_W'(c)];
          end
          freq_prev_nxt[CH_W'(c)] = f;
          inst_prev_nxt[CH_W'(c)] = inst_nxt[CH_W'(c)];
          ofreq_nxt[CH_W'(c)]     = f[15:0];
          oinst_nxt[CH_W'(c)]     = inst_nxt[CH_W'(c)];
          det_nxt[CH_W'(c)]       = '0;
        end
        if (first_nxt) begin
          mask_nxt = MASK_FIRST_ROW;
        end
        first_nxt = 1'b0;
      end
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_speed_r <= INIT_SPEED_RST;
    end else if (cfg_wr_en) begin
      init_speed_r <= cfg_wr_data;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        div_r[CH_W'(c)]       <= '0;
        quot_r[CH_W'(c)]      <= '0;
        inst_r[CH_W'(c)]      <= '0;
        inst_prev_r[CH_W'(c)] <= '0;
        freq_prev_r[CH_W'(c)] <= '0;
        det_r[CH_W'(c)]       <= '0;
      end
      trig_r  <= '0;
      speed_r <= INIT_SPEED_RST;
      loop_r  <= '0;
      first_r <= 1'b1;
    end else begin
      div_r       <= div_nxt;
      quot_r      <= quot_nxt;
      inst_r      <= inst_nxt;
      inst_prev_r <= inst_prev_nxt;
      freq_prev_r <= freq_prev_nxt;
      det_r       <= det_nxt;
      trig_r      <= trig_nxt;
      speed_r     <= speed_nxt;
      loop_r      <= loop_nxt;
      first_r     <= first_nxt;
    end
  end

  // output register: valid with reset, payload without
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mask_r   <= mask_nxt;
      ospeed_r <= speed_nxt;
      oloop_r  <= loop_nxt;
      ofreq_r  <= ofreq_nxt;
      oinst_r  <= oinst_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_change_mask    = mask_r;
  assign out_row_speed      = ospeed_r;
  assign out_loop_point     = oloop_r;
  assign out_freq_ch0       = ofreq_r[0];
  assign out_freq_ch1       = ofreq_r[1];
  assign out_freq_ch2       = ofreq_r[2];
  assign out_freq_ch3       = ofreq_r[3];
  assign out_instrument_ch0 = oinst_r[0];
  assign out_instrument_ch1 = oinst_r[1];
  assign out_instrument_ch2 = oinst_r[2];
  assign out_instrument_ch3 = oinst_r[3];

endmodule

`default_nettype wire

/* hw/rtl/xprd_checker.sv */
// ----------------------------------------------------------------------------
// xprd_checker: port-level checks for the pattern row decoder
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module xprd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  in_data_byte,
  input wire logic        in_pattern_start,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [7:0]  out_change_mask,
  input wire logic [7:0]  out_row_speed,
  input wire logic [15:0] out_freq_ch0,
  input wire logic [15:0] out_freq_ch1,
  input wire logic [15:0] out_freq_ch2,
  input wire logic [15:0] out_freq_ch3,
  input wire logic [7:0]  out_instrument_ch0,
  input wire logic [7:0]  out_instrument_ch1,
  input wire logic [7:0]  out_instrument_ch2,
  input wire logic [7:0]  out_instrument_ch3,
  input wire logic [7:0]  out_loop_point
);

  // no result beat right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data_byte) &&
      $stable(in_pattern_start))
    else $error("stalled input beat changed");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_change_mask) &&
      $stable(out_row_speed) && $stable(out_freq_ch0) && $stable(out_freq_ch1) &&
      $stable(out_freq_ch2) && $stable(out_freq_ch3) &&
      $stable(out_instrument_ch0) && $stable(out_instrument_ch1) &&
      $stable(out_instrument_ch2) && $stable(out_instrument_ch3) &&
      $stable(out_loop_point))
    else $error("stalled result beat changed");

  // only the four channel bits can be set in the change mask
  a_mask_bits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_change_mask & 8'h3A) == 8'h00)
    else $error("change mask has a non-channel bit");

  // loop point is a doubled parameter, always even
  a_loop_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_loop_point[0])
    else $error("odd loop point");

endmodule

bind xm_pattern_row_decoder xprd_checker u_xprd_checker (.*);

`default_nettype wire
